[sv/ecc_pkg.sv]
// Shared types and codes for the elevator car controller.
// No dependencies; used by every file of the block.
package ecc_pkg;

  localparam int FLOOR_W = 6;
  localparam int SLOT_W  = 5;  // enough for up to 32 list slots
  localparam int FILL_W  = 6;  // fill level up to 32

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_HAZARD = 2'd2;

  localparam logic [1:0] DIR_IDLE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_CLOSED = 3'd1;
  localparam logic [2:0] EV_OPENED = 3'd2;
  localparam logic [2:0] EV_UP     = 3'd3;
  localparam logic [2:0] EV_DOWN   = 3'd4;
  localparam logic [2:0] EV_HELD   = 3'd5;

  localparam logic [6:0] FLOOR_COUNT_RST = 7'd8;

  // Commands broadcast from the controller to every cell.
  typedef struct packed {
    logic               append;
    logic               remove;
    logic [FLOOR_W-1:0] wr_floor;
    logic [SLOT_W-1:0]  wr_slot;
    logic [SLOT_W-1:0]  rm_slot;
    logic [FILL_W-1:0]  fill;
    logic [FLOOR_W-1:0] car_floor;
  } cell_cmd_t;

  // Scan token walking the cell row: direction fold and first match.
  typedef struct packed {
    logic              valid;
    logic              seeded;
    logic              fold_pos;
    logic              fold_neg;
    logic              found;
    logic [SLOT_W-1:0] match_idx;
  } scan_tok_t;

endpackage

[sv/ecc_cell.sv]
// One slot of the request list plus one stage of the scan pipeline.
// Depends on ecc_pkg.
module ecc_cell #(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ecc_pkg::cell_cmd_t          cmd,
  input  logic [ecc_pkg::FLOOR_W-1:0] next_floor,
  input  ecc_pkg::scan_tok_t          tok_in,
  output logic [ecc_pkg::FLOOR_W-1:0] floor_q,
  output ecc_pkg::scan_tok_t          tok_out
);

  logic               active;
  logic               d_pos;
  logic               d_neg;
  logic               tok_vld;
  ecc_pkg::scan_tok_t tok_n;
  ecc_pkg::scan_tok_t tok_q;

  assign active = ecc_pkg::FILL_W'(IDX) < cmd.fill;
  assign d_pos  = floor_q > cmd.car_floor;
  assign d_neg  = floor_q < cmd.car_floor;

  // Fold: first active entry seeds the sign, later ones flip it when opposite.
  always_comb begin
    tok_n = tok_in;
    if (active) begin
      if (!tok_in.seeded) begin
        tok_n.seeded   = 1'b1;
        tok_n.fold_pos = d_pos;
        tok_n.fold_neg = d_neg;
      end else if ((d_pos && tok_in.fold_neg) || (d_neg && tok_in.fold_pos)) begin
        tok_n.fold_pos = d_pos;
        tok_n.fold_neg = d_neg;
      end
      if (!tok_in.found && !d_pos && !d_neg) begin
        tok_n.found     = 1'b1;
        tok_n.match_idx = ecc_pkg::SLOT_W'(IDX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_vld <= 1'b0;
    end else begin
      tok_vld <= tok_in.valid;
    end
    if (tok_in.valid) begin
      tok_q <= tok_n;
    end
    // Append into own slot, or close the gap left by a removed entry.
    if (cmd.append && (cmd.wr_slot == ecc_pkg::SLOT_W'(IDX))) begin
      floor_q <= cmd.wr_floor;
    end else if (cmd.remove && (ecc_pkg::SLOT_W'(IDX) >= cmd.rm_slot)) begin
      floor_q <= next_floor;
    end
  end

  always_comb begin
    tok_out       = tok_q;
    tok_out.valid = tok_vld;
  end

endmodule

[sv/elevator_car_controller_top.sv]
// Top level of the elevator car controller: sequencer, car state and
// the row of request cells. Depends on ecc_pkg and ecc_cell.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid/in_ready, op, dest_floor, *_in flags   | sink
//  out     | out_valid/out_ready, current_floor .. dropped   | source
//  cfg     | cfg_wr_en, cfg_wr_data (floor_count)            | sink
//
// A tick beat sends the scan token down the cell row one cell per cycle,
// then the commit state applies the result. Add and hazard beats go
// straight to commit. rst is synchronous; it empties the list, parks the
// car at floor 0 with the door closed and floor_count at 8. The output beat
// sits in a register; a new input beat is taken while it waits, and only the
// commit of the next one stalls until out_ready frees the register.
module elevator_car_controller_top #(
  parameter int MAX_REQUESTS = 8,
  parameter int MAX_FLOORS   = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] op,
  input  logic [5:0] dest_floor,
  input  logic       overload_in,
  input  logic       obstacle_in,
  input  logic       fire_in,
  input  logic       outage_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] current_floor,
  output logic [1:0] travel_dir,
  output logic       door_is_open,
  output logic [2:0] event_code,
  output logic       evacuate_fire,
  output logic       evacuate_outage,
  output logic [3:0] pending_count,
  output logic       request_dropped
);

  localparam int         CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam logic [8:0] MAXF  = 9'(MAX_FLOORS);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT} state_t;

  state_t     state;
  logic [6:0] floor_count;

  // item held while it is worked on
  logic [1:0] item_op;
  logic [5:0] item_dest;
  logic       item_ovl, item_obs, item_fire, item_out;

  // car state
  logic [CNT_W-1:0] fill, fill_next;
  logic [5:0]       car_floor, car_next;
  logic [1:0]       car_dir, dir_next, dir_dec;
  logic             door, door_next;
  logic             hz_ovl, hz_obs, hz_fire, hz_out;
  logic             hz_ovl_next, hz_obs_next, hz_fire_next, hz_out_next;

  logic [2:0] ev;
  logic       evf, evo, drop, do_append, do_remove;
  logic       slot_free, commit;
  logic [8:0] floors_used, top_floor;
  logic       can_up;

  ecc_pkg::cell_cmd_t cmd;
  ecc_pkg::scan_tok_t tok [MAX_REQUESTS+1];
  logic [5:0]         cell_floor [MAX_REQUESTS];
  ecc_pkg::scan_tok_t tail;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign commit    = (state == S_COMMIT) && slot_free;
  assign tail      = tok[MAX_REQUESTS];

  // Clamp the floor count to 2 .. MAX_FLOORS.
  always_comb begin
    if (floor_count < 7'd2) begin
      floors_used = 9'd2;
    end else if ({2'b0, floor_count} > MAXF) begin
      floors_used = MAXF;
    end else begin
      floors_used = {2'b0, floor_count};
    end
  end
  assign top_floor = floors_used - 9'd1;
  assign can_up    = (car_floor != 6'd63) && (({3'b0, car_floor} + 9'd1) < MAXF);

  // Scan launch: token enters cell 0 on the edge that takes a tick beat.
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = in_valid && in_ready && (op == ecc_pkg::OP_TICK);
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_REQUESTS; gi++) begin : g_cell
      logic [5:0] nbr;
      if (gi == MAX_REQUESTS - 1) begin : g_last
        assign nbr = cell_floor[gi];
      end else begin : g_mid
        assign nbr = cell_floor[gi+1];
      end
      ecc_cell #(.IDX(gi)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .cmd        (cmd),
        .next_floor (nbr),
        .tok_in     (tok[gi]),
        .floor_q    (cell_floor[gi]),
        .tok_out    (tok[gi+1])
      );
    end
  endgenerate

  // Direction: empty list idles, the end floors force a turn, else fold sign.
  always_comb begin
    if (fill == '0) begin
      dir_dec = ecc_pkg::DIR_IDLE;
    end else if (car_floor == 6'd0) begin
      dir_dec = ecc_pkg::DIR_UP;
    end else if ({3'b0, car_floor} == top_floor) begin
      dir_dec = ecc_pkg::DIR_DOWN;
    end else if (tail.fold_pos) begin
      dir_dec = ecc_pkg::DIR_UP;
    end else if (tail.fold_neg) begin
      dir_dec = ecc_pkg::DIR_DOWN;
    end else begin
      dir_dec = ecc_pkg::DIR_IDLE;
    end
  end

  // Effect of the held item on the car state.
  always_comb begin
    fill_next    = fill;
    car_next     = car_floor;
    dir_next     = car_dir;
    door_next    = door;
    hz_ovl_next  = hz_ovl;
    hz_obs_next  = hz_obs;
    hz_fire_next = hz_fire;
    hz_out_next  = hz_out;
    ev           = ecc_pkg::EV_NONE;
    evf          = 1'b0;
    evo          = 1'b0;
    drop         = 1'b0;
    do_append    = 1'b0;
    do_remove    = 1'b0;
    case (item_op)
      ecc_pkg::OP_TICK: begin
        dir_next = dir_dec;
        if (door) begin
          // an open door always closes first
          door_next = 1'b0;
          ev        = ecc_pkg::EV_CLOSED;
        end else if (fill == '0) begin
          ev = ecc_pkg::EV_NONE;
        end else if (tail.found) begin
          evf          = hz_fire;
          evo          = hz_out;
          hz_fire_next = 1'b0;
          hz_out_next  = 1'b0;
          door_next    = 1'b1;
          do_remove    = 1'b1;
          fill_next    = fill - CNT_W'(1);
          ev           = ecc_pkg::EV_OPENED;
        end else if (hz_ovl || hz_obs) begin
          ev = ecc_pkg::EV_HELD;
        end else if (dir_dec == ecc_pkg::DIR_UP) begin
          if (can_up) begin
            car_next = car_floor + 6'd1;
            ev       = ecc_pkg::EV_UP;
          end
        end else if (dir_dec == ecc_pkg::DIR_DOWN) begin
          if (car_floor != 6'd0) begin
            car_next = car_floor - 6'd1;
            ev       = ecc_pkg::EV_DOWN;
          end
        end
      end
      ecc_pkg::OP_ADD: begin
        if ((fill == CNT_W'(MAX_REQUESTS)) || ({3'b0, item_dest} >= floors_used)) begin
          drop = 1'b1;
        end else begin
          do_append = 1'b1;
          fill_next = fill + CNT_W'(1);
        end
      end
      ecc_pkg::OP_HAZARD: begin
        hz_ovl_next  = item_ovl;
        hz_obs_next  = item_obs;
        hz_fire_next = item_fire;
        hz_out_next  = item_out;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.append    = commit && do_append;
    cmd.remove    = commit && do_remove;
    cmd.wr_floor  = item_dest;
    cmd.wr_slot   = ecc_pkg::SLOT_W'(fill);
    cmd.rm_slot   = tail.match_idx;
    cmd.fill      = ecc_pkg::FILL_W'(fill);
    cmd.car_floor = car_floor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      floor_count <= ecc_pkg::FLOOR_COUNT_RST;
      fill        <= '0;
      car_floor   <= 6'd0;
      car_dir     <= ecc_pkg::DIR_IDLE;
      door        <= 1'b0;
      hz_ovl      <= 1'b0;
      hz_obs      <= 1'b0;
      hz_fire     <= 1'b0;
      hz_out      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        floor_count <= cfg_wr_data;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item_op   <= op;
            item_dest <= dest_floor;
            item_ovl  <= overload_in;
            item_obs  <= obstacle_in;
            item_fire <= fire_in;
            item_out  <= outage_in;
            state     <= (op == ecc_pkg::OP_TICK) ? S_SCAN : S_COMMIT;
          end
        end
        S_SCAN: begin
          if (tail.valid) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (commit) begin
        out_valid       <= 1'b1;
        fill            <= fill_next;
        car_floor       <= car_next;
        car_dir         <= dir_next;
        door            <= door_next;
        hz_ovl          <= hz_ovl_next;
        hz_obs          <= hz_obs_next;
        hz_fire         <= hz_fire_next;
        hz_out          <= hz_out_next;
        current_floor   <= car_next;
        travel_dir      <= dir_next;
        door_is_open    <= door_next;
        event_code      <= ev;
        evacuate_fire   <= evf;
        evacuate_outage <= evo;
        pending_count   <= 4'(fill_next);
        request_dropped <= drop;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[sv/ecc_checker.sv]
// Port-level checks for the elevator car controller, bound to the top.
// Depends on ecc_pkg and elevator_car_controller_top.
module ecc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] current_floor,
  input logic       door_is_open,
  input logic [2:0] event_code,
  input logic       evacuate_fire,
  input logic       evacuate_outage,
  input logic       request_dropped
);

  // A taken beat keeps the input side closed on the next cycle.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an input beat");

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(current_floor)
      && $stable(event_code))
    else $error("output beat changed while stalled");

  // Evacuation only comes with the door opening.
  a_evac_open: assert property (@(posedge clk) disable iff (rst)
    out_valid && (evacuate_fire || evacuate_outage) |->
      event_code == ecc_pkg::EV_OPENED && door_is_open)
    else $error("evacuation without door opening");

  // A dropped request causes no car event.
  a_drop_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && request_dropped |-> event_code == ecc_pkg::EV_NONE
      && !evacuate_fire && !evacuate_outage)
    else $error("dropped request with a car event");

  // Door events agree with the reported door state.
  a_door_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_code == ecc_pkg::EV_CLOSED || event_code == ecc_pkg::EV_UP
      || event_code == ecc_pkg::EV_DOWN) |-> !door_is_open)
    else $error("door open after close or move");

endmodule

bind elevator_car_controller_top ecc_checker u_ecc_checker (.*);

[tb/tb_elevator_car_controller_top.sv]
// Self-checking testbench for elevator_car_controller_top: a directed
// table, then random phases, each beat checked against a typed-in result
// or a behavioral car model. Depends on ecc_pkg and the controller RTL only.
module tb_elevator_car_controller_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Must match the defaults of the block under test.
  localparam int MAX_REQ = 8;
  localparam int MAX_FL  = 64;

  // op 3 is not decoded by the block; it must report nothing and change nothing.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Hazard masks for table rows: {overload, obstacle, fire, outage}.
  localparam logic [3:0] HZ_NONE     = 4'b0000;
  localparam logic [3:0] HZ_OVERLOAD = 4'b1000;
  localparam logic [3:0] HZ_OBSTACLE = 4'b0100;
  localparam logic [3:0] HZ_FIRE     = 4'b0010;
  localparam logic [3:0] HZ_OUTAGE   = 4'b0001;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE_CYCLS = MAX_REQ + 4;  // one tick beat plus output register
  localparam int LONG_HOLD    = 300;
  localparam int PHASES       = 14;
  localparam int PHASE_BEATS  = 110;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] dest;
    logic       ovl;
    logic       obs;
    logic       fire;
    logic       outage;
  } beat_t;

  typedef struct packed {
    logic [5:0] current_floor;
    logic [1:0] travel_dir;
    logic       door_is_open;
    logic [2:0] event_code;
    logic       evacuate_fire;
    logic       evacuate_outage;
    logic [3:0] pending_count;
    logic       request_dropped;
  } result_t;

  typedef enum {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    beat_t      beat;
    bit         has_lit;    // expected result typed into the table
    result_t    lit;
    logic [6:0] cfg_val;
  } row_t;

  // ---------------------------------------------------------------------------
  // DUT signals. Every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [6:0] cfg_wr_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] op = ecc_pkg::OP_TICK;
  logic [5:0] dest_floor = '0;
  logic       overload_in = 1'b0;
  logic       obstacle_in = 1'b0;
  logic       fire_in = 1'b0;
  logic       outage_in = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [5:0] current_floor;
  logic [1:0] travel_dir;
  logic       door_is_open;
  logic [2:0] event_code;
  logic       evacuate_fire;
  logic       evacuate_outage;
  logic [3:0] pending_count;
  logic       request_dropped;

  elevator_car_controller_top uut (.*);

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Car model: a private copy of the controller state, advanced once per
  // accepted input beat. Config is tracked in floors_cfg.
  // ---------------------------------------------------------------------------
  logic [5:0] list_floor [MAX_REQ];
  int         list_len = 0;
  logic [5:0] car_at = '0;
  logic [1:0] heading = ecc_pkg::DIR_IDLE;
  bit         door_open = 1'b0;
  bit         haz_overload = 1'b0;
  bit         haz_obstacle = 1'b0;
  bit         haz_fire = 1'b0;
  bit         haz_outage = 1'b0;
  logic [6:0] floors_cfg = ecc_pkg::FLOOR_COUNT_RST;

  result_t    car_reports_q [$];  // expected output beats, oldest first
  row_t       plan [$];
  int         mismatches = 0;
  int         reports_seen = 0;
  int         cycle_count = 0;

  // Knobs shared by the driver, the output sink and the phase sequencer.
  bit         no_idle = 1'b0;
  bit         hold_req = 1'b0;
  int         hold_left = 0;
  int         stall_left = 0;

  // Register value is clamped to 2..MAX_FL before use.
  function automatic logic [6:0] floors_served();
    if (floors_cfg < 7'd2) return 7'd2;
    if (floors_cfg > MAX_FL) return 7'(MAX_FL);
    return floors_cfg;
  endfunction

  // Direction rule: idle on empty list, forced at the ends, else the sign of a
  // fold that keeps the first request and flips to any one on the other side.
  function automatic logic [1:0] choose_heading();
    int fold;
    int d;
    int i;
    if (list_len == 0) return ecc_pkg::DIR_IDLE;
    if (car_at == 6'd0) return ecc_pkg::DIR_UP;
    if (car_at == floors_served() - 7'd1) return ecc_pkg::DIR_DOWN;
    fold = int'(list_floor[0]) - int'(car_at);
    for (i = 1; i < list_len; i++) begin
      d = int'(list_floor[i]) - int'(car_at);
      if ((d > 0 && fold < 0) || (d < 0 && fold > 0)) fold = d;
    end
    if (fold > 0) return ecc_pkg::DIR_UP;
    if (fold < 0) return ecc_pkg::DIR_DOWN;
    return ecc_pkg::DIR_IDLE;
  endfunction

  function automatic result_t advance_car(beat_t b);
    result_t r;
    int hit;
    int i;
    r = '0;
    case (b.op)
      ecc_pkg::OP_TICK: begin
        heading = choose_heading();
        hit = -1;
        if (door_open) begin
          // an open door always closes first, list or no list
          door_open = 1'b0;
          r.event_code = ecc_pkg::EV_CLOSED;
        end else if (list_len != 0) begin
          for (i = 0; i < list_len; i++)
            if (hit < 0 && list_floor[i] == car_at) hit = i;
          if (hit >= 0) begin
            r.evacuate_fire   = haz_fire;
            r.evacuate_outage = haz_outage;
            haz_fire   = 1'b0;
            haz_outage = 1'b0;
            door_open  = 1'b1;
            for (i = hit; i < list_len - 1; i++) list_floor[i] = list_floor[i + 1];
            list_len--;
            r.event_code = ecc_pkg::EV_OPENED;
          end else if (haz_overload || haz_obstacle) begin
            r.event_code = ecc_pkg::EV_HELD;
          end else if (heading == ecc_pkg::DIR_UP && car_at < 6'd63) begin
            car_at++;
            r.event_code = ecc_pkg::EV_UP;
          end else if (heading == ecc_pkg::DIR_DOWN && car_at > 6'd0) begin
            car_at--;
            r.event_code = ecc_pkg::EV_DOWN;
          end
        end
      end
      ecc_pkg::OP_ADD: begin
        if (list_len >= MAX_REQ || {1'b0, b.dest} >= floors_served()) begin
          r.request_dropped = 1'b1;
        end else begin
          list_floor[list_len] = b.dest;
          list_len++;
        end
      end
      ecc_pkg::OP_HAZARD: begin
        haz_overload = b.ovl;
        haz_obstacle = b.obs;
        haz_fire     = b.fire;
        haz_outage   = b.outage;
      end
      default: ;  // unused op: state untouched
    endcase
    r.current_floor = car_at;
    r.travel_dir    = heading;
    r.door_is_open  = door_open;
    r.pending_count = 4'(list_len);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Table helpers
  // ---------------------------------------------------------------------------
  function automatic result_t res(logic [5:0] fl, logic [1:0] dir, logic door,
                                  logic [2:0] ev, logic fire, logic outage,
                                  logic [3:0] pend, logic drop);
    return '{fl, dir, door, ev, fire, outage, pend, drop};
  endfunction

  function automatic row_t beat_row(logic [1:0] o, logic [5:0] d, logic [3:0] hz);
    row_t row;
    row.kind    = ROW_BEAT;
    row.beat    = '{o, d, hz[3], hz[2], hz[1], hz[0]};
    row.has_lit = 1'b0;
    row.lit     = '0;
    row.cfg_val = '0;
    return row;
  endfunction

  function automatic row_t lit_row(logic [1:0] o, logic [5:0] d, logic [3:0] hz,
                                   result_t want);
    row_t row;
    row = beat_row(o, d, hz);
    row.has_lit = 1'b1;
    row.lit     = want;
    return row;
  endfunction

  function automatic row_t cfg_row(logic [6:0] v);
    row_t row;
    row = beat_row(ecc_pkg::OP_TICK, '0, HZ_NONE);
    row.kind    = ROW_CFG;
    row.cfg_val = v;
    return row;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch: beat %0d %s expected %0d got %0d", reports_seen, what, want, got);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: payload and valid change on the falling edge; acceptance is
  // seen on the rising edge. Valid stays high across back-to-back beats.
  // ---------------------------------------------------------------------------
  task automatic drive_beat(input beat_t b, input bit has_lit, input result_t lit);
    int gap;
    result_t want;
    gap = no_idle ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    op          <= b.op;
    dest_floor  <= b.dest;
    overload_in <= b.ovl;
    obstacle_in <= b.obs;
    fire_in     <= b.fire;
    outage_in   <= b.outage;
    do @(posedge clk); while (!in_ready);
    want = advance_car(b);
    // typed-in rows still advance the model so later rows stay in step
    car_reports_q.push_back(has_lit ? lit : want);
  endtask

  // Drop valid, wait until every expected beat is back, then let a tick's
  // worth of cycles pass so the block is truly idle.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (car_reports_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLS) @(posedge clk);
  endtask

  task automatic write_floor_count(input logic [6:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    floors_cfg = v;
  endtask

  // Random beat: ticks dominate so the car actually travels; adds mostly land
  // in range; hazard writes lean to fire/outage to exercise evacuation.
  function automatic beat_t random_beat();
    beat_t b;
    int r;
    b = '{ecc_pkg::OP_TICK, 6'($urandom_range(0, 63)), 1'($urandom), 1'($urandom),
          1'($urandom), 1'($urandom)};
    r = $urandom_range(0, 99);
    if (r < 48) begin
      b.op = ecc_pkg::OP_TICK;
    end else if (r < 78) begin
      b.op = ecc_pkg::OP_ADD;
      if ($urandom_range(0, 9) < 8)
        b.dest = 6'($urandom_range(0, int'(floors_served()) - 1));
    end else if (r < 96) begin
      b.op     = ecc_pkg::OP_HAZARD;
      b.ovl    = ($urandom_range(0, 3) == 0);
      b.obs    = ($urandom_range(0, 3) == 0);
      b.fire   = ($urandom_range(0, 4) < 2);
      b.outage = ($urandom_range(0, 4) < 2);
    end else begin
      b.op = OP_UNUSED;  // noise with random payload
    end
    return b;
  endfunction

  function automatic logic [6:0] phase_floor_count(int ph);
    case (ph)
      1: return 7'd0;     // clamps up to 2
      2: return 7'd127;   // clamps down to 64
      4: return 7'd64;
      6: return 7'd1;
      7: return 7'd65;
      8: return 7'd2;
      default: begin
        if ($urandom_range(0, 9) < 7) return 7'($urandom_range(2, 12));
        return 7'($urandom_range(2, 64));
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Output sink: random back-pressure, plus one long hold on request.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Checker: each output beat against the oldest expectation, field by field.
  always @(posedge clk) begin : check_outputs
    result_t want;
    if (!rst && out_valid && out_ready) begin
      reports_seen++;
      if (car_reports_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: beat %0d arrived with nothing expected", reports_seen);
      end else begin
        want = car_reports_q.pop_front();
        if (current_floor !== want.current_floor)
          note_mismatch("current_floor", want.current_floor, current_floor);
        if (travel_dir !== want.travel_dir)
          note_mismatch("travel_dir", want.travel_dir, travel_dir);
        if (door_is_open !== want.door_is_open)
          note_mismatch("door_is_open", want.door_is_open, door_is_open);
        if (event_code !== want.event_code)
          note_mismatch("event_code", want.event_code, event_code);
        if (evacuate_fire !== want.evacuate_fire)
          note_mismatch("evacuate_fire", want.evacuate_fire, evacuate_fire);
        if (evacuate_outage !== want.evacuate_outage)
          note_mismatch("evacuate_outage", want.evacuate_outage, evacuate_outage);
        if (pending_count !== want.pending_count)
          note_mismatch("pending_count", want.pending_count, pending_count);
        if (request_dropped !== want.request_dropped)
          note_mismatch("request_dropped", want.request_dropped, request_dropped);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin : run
    int ph;
    beat_t nb;
    int k;

    // Directed table. Starts from reset: floor 0, idle, door shut, 8 floors.
    plan.push_back(lit_row(ecc_pkg::OP_TICK, 6'd0, HZ_NONE,  // empty list: nothing happens
                           res(0, ecc_pkg::DIR_IDLE, 0, ecc_pkg::EV_NONE, 0, 0, 0, 0)));
    plan.push_back(lit_row(OP_UNUSED, 6'd63, HZ_OVERLOAD | HZ_FIRE,
                           res(0, ecc_pkg::DIR_IDLE, 0, ecc_pkg::EV_NONE, 0, 0, 0, 0)));
    plan.push_back(lit_row(ecc_pkg::OP_ADD, 6'd63, HZ_NONE,  // beyond top floor: dropped
                           res(0, ecc_pkg::DIR_IDLE, 0, ecc_pkg::EV_NONE, 0, 0, 0, 1)));
    plan.push_back(lit_row(ecc_pkg::OP_ADD, 6'd7, HZ_NONE,
                           res(0, ecc_pkg::DIR_IDLE, 0, ecc_pkg::EV_NONE, 0, 0, 1, 0)));
    plan.push_back(lit_row(ecc_pkg::OP_ADD, 6'd0, HZ_NONE,
                           res(0, ecc_pkg::DIR_IDLE, 0, ecc_pkg::EV_NONE, 0, 0, 2, 0)));
    plan.push_back(lit_row(ecc_pkg::OP_HAZARD, 6'd0, HZ_FIRE | HZ_OUTAGE,
                           res(0, ecc_pkg::DIR_IDLE, 0, ecc_pkg::EV_NONE, 0, 0, 2, 0)));
    // floor 0 forces up; second entry matches: open with both evacuations
    plan.push_back(lit_row(ecc_pkg::OP_TICK, 6'd0, HZ_NONE,
                           res(0, ecc_pkg::DIR_UP, 1, ecc_pkg::EV_OPENED, 1, 1, 1, 0)));
    plan.push_back(lit_row(ecc_pkg::OP_TICK, 6'd0, HZ_NONE,
                           res(0, ecc_pkg::DIR_UP, 0, ecc_pkg::EV_CLOSED, 0, 0, 1, 0)));
    plan.push_back(lit_row(ecc_pkg::OP_HAZARD, 6'd0, HZ_OVERLOAD | HZ_OBSTACLE,
                           res(0, ecc_pkg::DIR_UP, 0, ecc_pkg::EV_NONE, 0, 0, 1, 0)));
    plan.push_back(lit_row(ecc_pkg::OP_TICK, 6'd0, HZ_NONE,
                           res(0, ecc_pkg::DIR_UP, 0, ecc_pkg::EV_HELD, 0, 0, 1, 0)));
    plan.push_back(lit_row(ecc_pkg::OP_HAZARD, 6'd0, HZ_NONE,
                           res(0, ecc_pkg::DIR_UP, 0, ecc_pkg::EV_NONE, 0, 0, 1, 0)));
    plan.push_back(lit_row(ecc_pkg::OP_TICK, 6'd0, HZ_NONE,
                           res(1, ecc_pkg::DIR_UP, 0, ecc_pkg::EV_UP, 0, 0, 1, 0)));
    // climb to the top floor and open there (top forces down)
    for (k = 0; k < 7; k++) plan.push_back(beat_row(ecc_pkg::OP_TICK, 6'd0, HZ_NONE));
    // shrink below the car: clamped to 2 floors, car stranded at 7
    plan.push_back(cfg_row(7'd0));
    plan.push_back(beat_row(ecc_pkg::OP_ADD, 6'd1, HZ_NONE));
    plan.push_back(beat_row(ecc_pkg::OP_ADD, 6'd2, HZ_NONE));
    plan.push_back(beat_row(ecc_pkg::OP_TICK, 6'd0, HZ_NONE));
    // widest setting, clamped to 64; requests on both sides of the car
    plan.push_back(cfg_row(7'd127));
    plan.push_back(beat_row(ecc_pkg::OP_ADD, 6'd63, HZ_NONE));
    plan.push_back(beat_row(ecc_pkg::OP_ADD, 6'd0, HZ_NONE));
    plan.push_back(beat_row(ecc_pkg::OP_TICK, 6'd0, HZ_NONE));
    plan.push_back(beat_row(ecc_pkg::OP_HAZARD, 6'd0,
                            HZ_OVERLOAD | HZ_OBSTACLE | HZ_FIRE | HZ_OUTAGE));
    plan.push_back(beat_row(ecc_pkg::OP_TICK, 6'd0, HZ_NONE));

    // synchronous reset, released on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        quiesce();
        write_floor_count(plan[i].cfg_val);
      end else begin
        drive_beat(plan[i].beat, plan[i].has_lit, plan[i].lit);
      end
    end

    // Random phases, each behind a fresh floor count. Two phases run with no
    // idling at all; one starts with a long sink hold so the block backs up
    // and stalls its input while the driver keeps offering.
    for (ph = 0; ph < PHASES; ph++) begin
      quiesce();
      write_floor_count(phase_floor_count(ph));
      no_idle = (ph == 3 || ph == 9);
      if (ph == 5) hold_req = 1'b1;
      repeat (PHASE_BEATS) begin
        nb = random_beat();
        drive_beat(nb, 1'b0, '0);
      end
    end

    quiesce();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
